// ===== hdl/hcg_pkg.sv =====
package hcg_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int COLOR_W     = CHAN_W * NUM_CHAN;
    localparam int CHAN_MAX    = 255;
    localparam int CFG_INDEX_W = 3;

    // Reset colors
    localparam logic [COLOR_W-1:0] TOP_COLOR_RST    = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] GROUND_COLOR_RST = 24'h00FF00;
    localparam logic [COLOR_W-1:0] BOTTOM_COLOR_RST = 24'h0000FF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEIGHT_MAX   = 3'd0,
        REG_HEIGHT_MIN   = 3'd1,
        REG_TOP_COLOR    = 3'd2,
        REG_GROUND_COLOR = 3'd3,
        REG_BOTTOM_COLOR = 3'd4
    } cfg_reg_t;

    // Side-band travelling with each request down the pipe
    typedef struct packed {
        logic                fixed;        // color already decided
        logic [COLOR_W-1:0]  fixed_color;
        logic [COLOR_W-1:0]  start_color;  // gradient start
        logic                span_zero;    // len == 0: keep start
        logic [NUM_CHAN-1:0] neg;          // quotient sign per channel
    } ctl_t;

endpackage

// ===== hdl/hcg_prep.sv =====
module hcg_prep #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    input  logic signed [HEIGHT_BITS-1:0]                   height,
    input  logic [hcg_pkg::COLOR_W-1:0]                     explicit_color,
    input  logic signed [HEIGHT_BITS-1:0]                   height_max,
    input  logic signed [HEIGHT_BITS-1:0]                   height_min,
    input  logic [hcg_pkg::COLOR_W-1:0]                     top_color,
    input  logic [hcg_pkg::COLOR_W-1:0]                     ground_color,
    input  logic [hcg_pkg::COLOR_W-1:0]                     bottom_color,
    output logic                                            out_valid,
    output hcg_pkg::ctl_t                                   ctl,
    output logic [hcg_pkg::NUM_CHAN-1:0][HEIGHT_BITS+9:0]   num,
    output logic [HEIGHT_BITS:0]                            den
);

    localparam int PW = HEIGHT_BITS + 1;   // pix / len
    localparam int MW = HEIGHT_BITS + 10;  // product
    localparam int NW = HEIGHT_BITS + 10;  // numerator
    localparam int DW = HEIGHT_BITS + 1;   // denominator
    localparam int DFW = hcg_pkg::CHAN_W + 1;

    // ---- stage A: select, pix, len, channel differences
    logic                  a_valid_reg;
    hcg_pkg::ctl_t         a_ctl_reg, a_ctl_next;
    logic signed [PW-1:0]  a_pix_reg, a_pix_next;
    logic signed [PW-1:0]  a_len_reg, a_len_next;
    logic signed [DFW-1:0] a_diff_reg [hcg_pkg::NUM_CHAN];
    logic signed [DFW-1:0] a_diff_next [hcg_pkg::NUM_CHAN];
    logic [hcg_pkg::COLOR_W-1:0] end_color;
    logic signed [PW-1:0]  h_ext, min_ext, max_ext;

    assign h_ext   = PW'(height);
    assign min_ext = PW'(height_min);
    assign max_ext = PW'(height_max);

    always_comb
    begin
        a_ctl_next = '0;
        a_pix_next = h_ext;
        a_len_next = max_ext;
        end_color  = top_color;
        a_ctl_next.start_color = ground_color;
        priority if (explicit_color != '0)
        begin
            a_ctl_next.fixed       = 1'b1;
            a_ctl_next.fixed_color = explicit_color;
        end
        else if (height == height_max)
        begin
            a_ctl_next.fixed       = 1'b1;
            a_ctl_next.fixed_color = top_color;
        end
        else if (height == '0)
        begin
            a_ctl_next.fixed       = 1'b1;
            a_ctl_next.fixed_color = ground_color;
        end
        else if (height == height_min && height_min != '0)
        begin
            a_ctl_next.fixed       = 1'b1;
            a_ctl_next.fixed_color = bottom_color;
        end
        else if (!height[HEIGHT_BITS-1])
        begin
            // upper gradient, defaults already set
            a_pix_next = h_ext;
        end
        else
        begin
            a_pix_next             = h_ext - min_ext;
            a_len_next             = -min_ext;
            a_ctl_next.start_color = bottom_color;
            end_color              = ground_color;
        end
        for (int c = 0; c < hcg_pkg::NUM_CHAN; c++)
        begin
            a_diff_next[c] = signed'({1'b0, end_color[hcg_pkg::CHAN_W*c +: hcg_pkg::CHAN_W]})
                - signed'({1'b0, a_ctl_next.start_color[hcg_pkg::CHAN_W*c +: hcg_pkg::CHAN_W]});
        end
    end

    // ---- stage B: products
    logic                 b_valid_reg;
    hcg_pkg::ctl_t        b_ctl_reg;
    logic signed [PW-1:0] b_len_reg;
    logic signed [MW-1:0] b_prod_reg [hcg_pkg::NUM_CHAN];
    logic signed [MW-1:0] b_prod_next [hcg_pkg::NUM_CHAN];

    always_comb
    begin
        for (int c = 0; c < hcg_pkg::NUM_CHAN; c++)
        begin
            b_prod_next[c] = MW'(a_pix_reg) * MW'(a_diff_reg[c]);
        end
    end

    // ---- stage C: magnitudes, rounding offset, sign
    logic                 c_valid_reg;
    hcg_pkg::ctl_t        c_ctl_reg, c_ctl_next;
    logic [hcg_pkg::NUM_CHAN-1:0][NW-1:0] c_num_reg, c_num_next;
    logic [DW-1:0]        c_den_reg, c_den_next;
    logic [PW-1:0]        len_mag;
    logic [MW-1:0]        prod_mag;

    always_comb
    begin
        len_mag    = b_len_reg[PW-1] ? PW'(-b_len_reg) : PW'(b_len_reg);
        prod_mag   = '0;
        c_ctl_next = b_ctl_reg;
        c_ctl_next.span_zero = (b_len_reg == '0);
        c_den_next = {len_mag[PW-2:0], 1'b0};
        for (int c = 0; c < hcg_pkg::NUM_CHAN; c++)
        begin
            prod_mag = b_prod_reg[c][MW-1] ? MW'(-b_prod_reg[c]) : MW'(b_prod_reg[c]);
            c_num_next[c]     = {prod_mag[NW-2:0], 1'b0} + NW'(len_mag);
            c_ctl_next.neg[c] = b_prod_reg[c][MW-1] ^ b_len_reg[PW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ctl_reg  <= a_ctl_next;
        a_pix_reg  <= a_pix_next;
        a_len_reg  <= a_len_next;
        a_diff_reg <= a_diff_next;
        b_ctl_reg  <= a_ctl_reg;
        b_len_reg  <= a_len_reg;
        b_prod_reg <= b_prod_next;
        c_ctl_reg  <= c_ctl_next;
        c_num_reg  <= c_num_next;
        c_den_reg  <= c_den_next;
    end

    assign out_valid = c_valid_reg;
    assign ctl       = c_ctl_reg;
    assign num       = c_num_reg;
    assign den       = c_den_reg;

endmodule

// ===== hdl/hcg_div_cell.sv =====
// One restoring-division step for all three channels.
module hcg_div_cell #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    input  hcg_pkg::ctl_t                                  in_ctl,
    input  logic [hcg_pkg::NUM_CHAN-1:0][HEIGHT_BITS+9:0]  in_nq,
    input  logic [hcg_pkg::NUM_CHAN-1:0][HEIGHT_BITS:0]    in_rem,
    input  logic [HEIGHT_BITS:0]                           in_den,
    output logic                                           out_valid,
    output hcg_pkg::ctl_t                                  out_ctl,
    output logic [hcg_pkg::NUM_CHAN-1:0][HEIGHT_BITS+9:0]  out_nq,
    output logic [hcg_pkg::NUM_CHAN-1:0][HEIGHT_BITS:0]    out_rem,
    output logic [HEIGHT_BITS:0]                           out_den
);

    localparam int NW = HEIGHT_BITS + 10;
    localparam int DW = HEIGHT_BITS + 1;

    logic                                 valid_reg;
    hcg_pkg::ctl_t                        ctl_reg;
    logic [hcg_pkg::NUM_CHAN-1:0][NW-1:0] nq_reg, nq_next;
    logic [hcg_pkg::NUM_CHAN-1:0][DW-1:0] rem_reg, rem_next;
    logic [DW-1:0]                        den_reg;
    logic [DW:0]                          trial;
    logic [DW:0]                          diff;

    always_comb
    begin
        trial = '0;
        diff  = '0;
        for (int c = 0; c < hcg_pkg::NUM_CHAN; c++)
        begin
            trial = {in_rem[c], in_nq[c][NW-1]};
            diff  = trial - {1'b0, in_den};
            if (trial >= {1'b0, in_den})
            begin
                rem_next[c] = diff[DW-1:0];
                nq_next[c]  = {in_nq[c][NW-2:0], 1'b1};
            end
            else
            begin
                rem_next[c] = trial[DW-1:0];
                nq_next[c]  = {in_nq[c][NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg <= in_ctl;
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        den_reg <= in_den;
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_nq    = nq_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;

endmodule

// ===== hdl/hcg_finish.sv =====
// Applies the quotient to the start color, clamps, output register.
module hcg_finish #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    input  hcg_pkg::ctl_t                                  in_ctl,
    input  logic [hcg_pkg::NUM_CHAN-1:0][HEIGHT_BITS+9:0]  quot,
    output logic                                           done,
    output logic [hcg_pkg::COLOR_W-1:0]                    rgb
);

    localparam int NW = HEIGHT_BITS + 10;

    logic                          done_reg;
    logic [hcg_pkg::COLOR_W-1:0]   rgb_reg, rgb_next;
    logic [hcg_pkg::COLOR_W-1:0]   grad;
    logic [hcg_pkg::CHAN_W-1:0]    s;
    logic [NW:0]                   sum;

    always_comb
    begin
        grad = '0;
        s    = '0;
        sum  = '0;
        for (int c = 0; c < hcg_pkg::NUM_CHAN; c++)
        begin
            s   = in_ctl.start_color[hcg_pkg::CHAN_W*c +: hcg_pkg::CHAN_W];
            sum = (NW+1)'(quot[c]) + (NW+1)'(s);
            if (in_ctl.span_zero)
            begin
                grad[hcg_pkg::CHAN_W*c +: hcg_pkg::CHAN_W] = s;
            end
            else if (in_ctl.neg[c])
            begin
                if (quot[c] > NW'(s))
                    grad[hcg_pkg::CHAN_W*c +: hcg_pkg::CHAN_W] = '0;
                else
                    grad[hcg_pkg::CHAN_W*c +: hcg_pkg::CHAN_W] =
                        s - quot[c][hcg_pkg::CHAN_W-1:0];
            end
            else if (sum > (NW+1)'(hcg_pkg::CHAN_MAX))
            begin
                grad[hcg_pkg::CHAN_W*c +: hcg_pkg::CHAN_W] = '1;
            end
            else
            begin
                grad[hcg_pkg::CHAN_W*c +: hcg_pkg::CHAN_W] = sum[hcg_pkg::CHAN_W-1:0];
            end
        end
        rgb_next = in_ctl.fixed ? in_ctl.fixed_color : grad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
    end

    assign done = done_reg;
    assign rgb  = rgb_reg;

endmodule

// ===== hdl/height_color_gradient.sv =====
// Pipeline: three prep stages, one division cell per numerator bit
//   (HEIGHT_BITS + 10 cells), one output stage.
// Throughput: one request per cycle; busy stays low, results never stall.
// Reset: rst_n is asynchronous, active low; clears the pipe valids and loads
//   the register reset values (max/min 0, top white, ground green, bottom blue).
module height_color_gradient #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [HEIGHT_BITS-1:0]         height,
    input  logic [hcg_pkg::COLOR_W-1:0]           explicit_color,
    // result channel
    output logic                                  done,
    output logic [hcg_pkg::COLOR_W-1:0]           rgb,
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [hcg_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [((HEIGHT_BITS > hcg_pkg::COLOR_W) ? HEIGHT_BITS
                   : hcg_pkg::COLOR_W)-1:0]       cfg_data
);

    // Numerator: 2*|pix*diff| + |len| needs HEIGHT_BITS+10 bits; the
    // denominator 2*|len| needs HEIGHT_BITS+1. The chain produces one
    // quotient bit per cell, so there are as many cells as numerator bits.
    localparam int NW    = HEIGHT_BITS + 10;
    localparam int DW    = HEIGHT_BITS + 1;
    localparam int CELLS = NW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [HEIGHT_BITS-1:0]   height_max_reg;
    logic signed [HEIGHT_BITS-1:0]   height_min_reg;
    logic [hcg_pkg::COLOR_W-1:0]     top_color_reg;
    logic [hcg_pkg::COLOR_W-1:0]     ground_color_reg;
    logic [hcg_pkg::COLOR_W-1:0]     bottom_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_max_reg   <= '0;
            height_min_reg   <= '0;
            top_color_reg    <= hcg_pkg::TOP_COLOR_RST;
            ground_color_reg <= hcg_pkg::GROUND_COLOR_RST;
            bottom_color_reg <= hcg_pkg::BOTTOM_COLOR_RST;
        end
        else if (cfg_wr_en)
        begin
            // indexes past the last register are dropped
            unique case (hcg_pkg::cfg_reg_t'(cfg_index))
                hcg_pkg::REG_HEIGHT_MAX:   height_max_reg   <= cfg_data[HEIGHT_BITS-1:0];
                hcg_pkg::REG_HEIGHT_MIN:   height_min_reg   <= cfg_data[HEIGHT_BITS-1:0];
                hcg_pkg::REG_TOP_COLOR:    top_color_reg    <= cfg_data[hcg_pkg::COLOR_W-1:0];
                hcg_pkg::REG_GROUND_COLOR: ground_color_reg <= cfg_data[hcg_pkg::COLOR_W-1:0];
                hcg_pkg::REG_BOTTOM_COLOR: bottom_color_reg <= cfg_data[hcg_pkg::COLOR_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Fully pipelined: a request is taken every cycle.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Prep: choose fixed color or gradient, multiply, form num/den
    // ------------------------------------------------------------------
    logic                                        chain_valid [CELLS+1];
    hcg_pkg::ctl_t                               chain_ctl   [CELLS+1];
    logic [hcg_pkg::NUM_CHAN-1:0][NW-1:0]        chain_nq    [CELLS+1];
    logic [hcg_pkg::NUM_CHAN-1:0][DW-1:0]        chain_rem   [CELLS+1];
    logic [DW-1:0]                               chain_den   [CELLS+1];

    hcg_prep #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_prep (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start & ~busy),
        .height         (height),
        .explicit_color (explicit_color),
        .height_max     (height_max_reg),
        .height_min     (height_min_reg),
        .top_color      (top_color_reg),
        .ground_color   (ground_color_reg),
        .bottom_color   (bottom_color_reg),
        .out_valid      (chain_valid[0]),
        .ctl            (chain_ctl[0]),
        .num            (chain_nq[0]),
        .den            (chain_den[0])
    );

    // partial remainder starts at zero
    assign chain_rem[0] = '0;

    // ------------------------------------------------------------------
    // Division chain: each cell shifts in one numerator bit and emits
    // one quotient bit into the same word; after the last cell the word
    // holds the rounded magnitude for each channel.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        hcg_div_cell #(
            .HEIGHT_BITS (HEIGHT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_ctl    (chain_ctl[k]),
            .in_nq     (chain_nq[k]),
            .in_rem    (chain_rem[k]),
            .in_den    (chain_den[k]),
            .out_valid (chain_valid[k+1]),
            .out_ctl   (chain_ctl[k+1]),
            .out_nq    (chain_nq[k+1]),
            .out_rem   (chain_rem[k+1]),
            .out_den   (chain_den[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Finish: signed add to start color, clamp to 0..255, output reg.
    // The final remainder and divisor are not needed.
    // ------------------------------------------------------------------
    hcg_finish #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[CELLS]),
        .in_ctl   (chain_ctl[CELLS]),
        .quot     (chain_nq[CELLS]),
        .done     (done),
        .rgb      (rgb)
    );

endmodule

// ===== hdl/hcg_checker.sv =====
module hcg_checker #(
    parameter int HEIGHT_BITS = 16
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [hcg_pkg::COLOR_W-1:0]       explicit_color,
    input logic                              done,
    input logic [hcg_pkg::COLOR_W-1:0]       rgb
);

    localparam int LAT = HEIGHT_BITS + 14;

    // pipe never back-pressures
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // every request gives exactly one result after the fixed latency
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing");

    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without request");

    // a nonzero explicit color passes through untouched
    a_explicit_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && explicit_color != '0)
            |-> ##LAT (done && rgb == $past(explicit_color, LAT)))
        else $error("explicit color altered");

endmodule

bind height_color_gradient hcg_checker #(
    .HEIGHT_BITS (HEIGHT_BITS)
) u_hcg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .explicit_color (explicit_color),
    .done           (done),
    .rgb            (rgb)
);

// ===== sim/tb_height_color_gradient.sv =====
`timescale 1ns / 1ps

// Tracks register contents, predicts the color of every accepted request and
// checks the results in order.
class color_scoreboard #(int HEIGHT_W = 16);

    localparam int CFG_W = (HEIGHT_W > hcg_pkg::COLOR_W) ? HEIGHT_W : hcg_pkg::COLOR_W;

    typedef struct {
        logic signed [HEIGHT_W-1:0]  height;
        logic [hcg_pkg::COLOR_W-1:0] explicit_color;
        logic [hcg_pkg::COLOR_W-1:0] rgb;
    } color_req_t;

    logic signed [HEIGHT_W-1:0]  height_max;
    logic signed [HEIGHT_W-1:0]  height_min;
    logic [hcg_pkg::COLOR_W-1:0] top_color;
    logic [hcg_pkg::COLOR_W-1:0] ground_color;
    logic [hcg_pkg::COLOR_W-1:0] bottom_color;

    color_req_t expected_colors[$];

    int mismatches;
    int requests;
    int explicit_hits;
    int gradient_hits;

    function new();
        height_max    = '0;
        height_min    = '0;
        top_color     = hcg_pkg::TOP_COLOR_RST;
        ground_color  = hcg_pkg::GROUND_COLOR_RST;
        bottom_color  = hcg_pkg::BOTTOM_COLOR_RST;
        mismatches    = 0;
        requests      = 0;
        explicit_hits = 0;
        gradient_hits = 0;
    endfunction

    // Only the low HEIGHT_W bits count for the height registers; other
    // indexes are dropped.
    function void note_config(logic [hcg_pkg::CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (hcg_pkg::cfg_reg_t'(idx))
            hcg_pkg::REG_HEIGHT_MAX:   height_max   = data[HEIGHT_W-1:0];
            hcg_pkg::REG_HEIGHT_MIN:   height_min   = data[HEIGHT_W-1:0];
            hcg_pkg::REG_TOP_COLOR:    top_color    = data[hcg_pkg::COLOR_W-1:0];
            hcg_pkg::REG_GROUND_COLOR: ground_color = data[hcg_pkg::COLOR_W-1:0];
            hcg_pkg::REG_BOTTOM_COLOR: bottom_color = data[hcg_pkg::COLOR_W-1:0];
            default: ;
        endcase
    endfunction

    // Per channel: from + round(pix * (to - from) / span), half away from
    // zero, then clamped to the channel range.
    function logic [hcg_pkg::COLOR_W-1:0] blend_channels(logic [hcg_pkg::COLOR_W-1:0] from_c,
                                                         logic [hcg_pkg::COLOR_W-1:0] to_c,
                                                         longint span, longint pix);
        logic [hcg_pkg::COLOR_W-1:0] mix;
        longint s, e, c, num, den;
        mix = '0;
        for (int k = 0; k < hcg_pkg::NUM_CHAN; k++)
        begin
            s = longint'(from_c[k*hcg_pkg::CHAN_W +: hcg_pkg::CHAN_W]);
            e = longint'(to_c[k*hcg_pkg::CHAN_W +: hcg_pkg::CHAN_W]);
            c = s;
            if (span != 0)
            begin
                num = pix * (e - s);
                den = span;
                if (den < 0)
                begin
                    den = -den;
                    num = -num;
                end
                if (num >= 0)
                    c = s + (2 * num + den) / (2 * den);
                else
                    c = s - (-2 * num + den) / (2 * den);
            end
            if (c < 0)
                c = 0;
            if (c > hcg_pkg::CHAN_MAX)
                c = hcg_pkg::CHAN_MAX;
            mix[k*hcg_pkg::CHAN_W +: hcg_pkg::CHAN_W] = c[hcg_pkg::CHAN_W-1:0];
        end
        return mix;
    endfunction

    function void note_request(logic signed [HEIGHT_W-1:0] h,
                               logic [hcg_pkg::COLOR_W-1:0] ec);
        color_req_t req;
        longint hl, mx, mn;
        hl = longint'(h);
        mx = longint'(height_max);
        mn = longint'(height_min);
        req.height         = h;
        req.explicit_color = ec;
        if (ec != '0)
        begin
            req.rgb = ec;
            explicit_hits++;
        end
        else if (hl == mx)
            req.rgb = top_color;
        else if (hl == 0)
            req.rgb = ground_color;
        else if (hl == mn && mn != 0)
            req.rgb = bottom_color;
        else
        begin
            gradient_hits++;
            if (hl > 0)
                req.rgb = blend_channels(ground_color, top_color, mx, hl);
            else
                req.rgb = blend_channels(bottom_color, ground_color, -mn, hl - mn);
        end
        requests++;
        expected_colors.push_back(req);
    endfunction

    function void check_result(logic [hcg_pkg::COLOR_W-1:0] rgb);
        color_req_t req;
        if (expected_colors.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %0d: unexpected result rgb %06h", mismatches, rgb);
            return;
        end
        req = expected_colors.pop_front();
        if (rgb !== req.rgb)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %0d: height %0d explicit %06h expected %06h got %06h",
                         mismatches, req.height, req.explicit_color, req.rgb, rgb);
        end
    endfunction

    function int pending();
        return expected_colors.size();
    endfunction

    // Anything still waiting at the end is a lost result.
    function void close();
        if (expected_colors.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_colors.size());
            mismatches += expected_colors.size();
            expected_colors.delete();
        end
    endfunction

endclass

module tb_height_color_gradient;

    localparam int HEIGHT_W    = 16;
    localparam int CFG_W       = (HEIGHT_W > hcg_pkg::COLOR_W) ? HEIGHT_W : hcg_pkg::COLOR_W;
    // accept edge to result edge
    localparam int LATENCY     = HEIGHT_W + 14;
    localparam int LIMIT       = 400000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 175;
    // indexes past the last register; writes there must change nothing
    localparam logic [hcg_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE_FIRST = 3'd5;
    localparam int HMAX_POS = 32767;
    localparam int HMIN_NEG = -32768;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic signed [HEIGHT_W-1:0]        height;
    logic [hcg_pkg::COLOR_W-1:0]       explicit_color;
    logic                              done;
    logic [hcg_pkg::COLOR_W-1:0]       rgb;
    logic                              cfg_wr_en;
    logic [hcg_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]                  cfg_data;

    color_scoreboard #(HEIGHT_W) sb;
    int settings_done;

    height_color_gradient #(
        .HEIGHT_BITS(HEIGHT_W)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .height         (height),
        .explicit_color (explicit_color),
        .done           (done),
        .rgb            (rgb),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops results.
    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Results last exactly one cycle; sample on the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(rgb);
    end

    // ------------------------------------------------------------------
    // Driver tasks. Everything changes on the falling edge; the block and
    // the scoreboard both see it at the next rising edge.
    // ------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. start stays
    // high afterwards so back-to-back requests need no gap between them.
    task automatic send_point(input int h,
                              input logic [hcg_pkg::COLOR_W-1:0] ec);
        @(negedge clk);
        start          = 1'b1;
        height         = HEIGHT_W'(h);
        explicit_color = ec;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(HEIGHT_W'(h), ec);
    endtask

    // Idle cycles with start low and junk on the payload.
    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start          = 1'b0;
            height         = HEIGHT_W'($urandom);
            explicit_color = hcg_pkg::COLOR_W'($urandom);
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Drop start, wait for every outstanding request, then let the pipe
    // run empty before anything touches the registers.
    task automatic drain_requests();
        idle_cycles(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [hcg_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        sb.note_config(idx, data);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Height registers get random upper bits to check they are dropped.
    task automatic write_height(input logic [hcg_pkg::CFG_INDEX_W-1:0] idx, input int val);
        logic [CFG_W-1:0] data;
        data = CFG_W'($urandom);
        data[HEIGHT_W-1:0] = val[HEIGHT_W-1:0];
        write_reg(idx, data);
    endtask

    task automatic write_all(input int mx, input int mn,
                             input logic [hcg_pkg::COLOR_W-1:0] top_c,
                             input logic [hcg_pkg::COLOR_W-1:0] ground_c,
                             input logic [hcg_pkg::COLOR_W-1:0] bottom_c);
        write_height(hcg_pkg::REG_HEIGHT_MAX, mx);
        write_height(hcg_pkg::REG_HEIGHT_MIN, mn);
        write_reg(hcg_pkg::REG_TOP_COLOR, top_c);
        write_reg(hcg_pkg::REG_GROUND_COLOR, ground_c);
        write_reg(hcg_pkg::REG_BOTTOM_COLOR, bottom_c);
        settings_done++;
    endtask

    function automatic logic [hcg_pkg::COLOR_W-1:0] random_color();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return hcg_pkg::COLOR_W'($urandom);
    endfunction

    // Well-formed heights dominate: exact max/min/zero, their neighbors,
    // points inside the range; the rest is anything the field allows.
    function automatic logic signed [HEIGHT_W-1:0] pick_height(input int mx, input int mn);
        int r, lo, hi;
        r  = $urandom_range(0, 99);
        lo = (mx < mn) ? mx : mn;
        hi = (mx < mn) ? mn : mx;
        if (r < 8)
            return HEIGHT_W'(mx);
        else if (r < 14)
            return HEIGHT_W'(mn);
        else if (r < 20)
            return '0;
        else if (r < 24)
            return HEIGHT_W'(mx - 1);
        else if (r < 28)
            return HEIGHT_W'(mn + 1);
        else if (r < 85)
            return HEIGHT_W'(lo + int'($urandom_range(0, hi - lo)));
        return HEIGHT_W'($urandom);
    endfunction

    function automatic logic [hcg_pkg::COLOR_W-1:0] pick_explicit();
        if ($urandom_range(0, 99) < 75)
            return '0;
        return hcg_pkg::COLOR_W'($urandom_range(1, (1 << hcg_pkg::COLOR_W) - 1));
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int mx, mn, kind;
        bit burst;

        sb             = new();
        settings_done  = 0;
        rst_n          = 1'b0;
        start          = 1'b0;
        height         = '0;
        explicit_color = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // Reset registers: max = min = 0, so zero height hits the top color
        // and both gradients have zero span (keep the start color).
        send_point(0, 0);
        send_point(1, 0);
        send_point(-1, 0);
        send_point(HMAX_POS, 0);
        send_point(HMIN_NEG, 0);
        send_point(100, '1);
        drain_requests();

        // Symmetric range, odd channel differences so the midpoints land
        // exactly on a half; far points extrapolate and saturate.
        write_all(1000, -1000, 24'h10FF80, 24'h7F807F, 24'h00FF20);
        send_point(1000, 0);
        send_point(-1000, 0);
        send_point(0, 0);
        send_point(500, 0);
        send_point(-500, 0);
        send_point(1, 0);
        send_point(-1, 0);
        send_point(HMAX_POS, 0);
        send_point(HMIN_NEG, 0);
        send_point(7, 24'h000001);
        drain_requests();

        // Inverted registers: negative spans on both sides. Writes to the
        // spare indexes must not disturb anything.
        write_all(-100, 100, 24'hFF0000, 24'h00FF00, 24'h0000FF);
        for (int i = CFG_IDX_SPARE_FIRST; i < (1 << hcg_pkg::CFG_INDEX_W); i++)
            write_reg(hcg_pkg::CFG_INDEX_W'(i), CFG_W'($urandom));
        send_point(50, 0);
        send_point(-50, 0);
        send_point(-100, 0);
        send_point(100, 0);
        send_point(0, 0);
        send_point(HMIN_NEG, 0);
        send_point(HMAX_POS, 0);
        drain_requests();

        // Random phases, each with a fresh register setting. Every phase
        // ends with a full drain, which also covers the sender pause.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            kind = p % 5;
            case (kind)
                0:
                begin
                    mx = HMAX_POS;
                    mn = HMIN_NEG;
                end
                1:
                begin
                    mx = $urandom_range(1, 20);
                    mn = -int'($urandom_range(1, 20));
                end
                2:
                begin
                    mx = $urandom_range(0, HMAX_POS);
                    mn = -int'($urandom_range(0, -HMIN_NEG));
                end
                3:
                begin
                    mx = $signed(HEIGHT_W'($urandom));
                    mn = $signed(HEIGHT_W'($urandom));
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        mx = 0;
                        mn = -int'($urandom_range(1, -HMIN_NEG));
                    end
                    else
                    begin
                        mx = $urandom_range(1, HMAX_POS);
                        mn = 0;
                    end
                end
            endcase
            write_all(mx, mn, random_color(), random_color(), random_color());
            if ($urandom_range(0, 2) == 0)
                write_reg(hcg_pkg::CFG_INDEX_W'($urandom_range(CFG_IDX_SPARE_FIRST,
                                                  (1 << hcg_pkg::CFG_INDEX_W) - 1)),
                          CFG_W'($urandom));

            // some phases run back to back with no gaps at all
            burst = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_point(pick_height(mx, mn), pick_explicit());
                if (!burst)
                    idle_cycles(gap_length());
            end
            drain_requests();
        end

        sb.close();
        $display("%0d requests checked over %0d register settings", sb.requests, settings_done);
        $display("%0d explicit colors, %0d gradient points, %0d mismatches",
                 sb.explicit_hits, sb.gradient_hits, sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/hcg_pkg.sv
hdl/hcg_prep.sv
hdl/hcg_div_cell.sv
hdl/hcg_finish.sv
hdl/height_color_gradient.sv
hdl/hcg_checker.sv
sim/tb_height_color_gradient.sv
